>>> rtl/decimal96_add_subtract_unit_defines.svh
// Assertion macros shared by the decimal add/subtract unit.
// No dependencies.
`ifndef DECIMAL96_ADD_SUBTRACT_UNIT_DEFINES_SVH
`define DECIMAL96_ADD_SUBTRACT_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define DAS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/das_pkg.sv
// Types and constants for the decimal add/subtract unit.
// No dependencies.
`default_nettype none
package das_pkg;
   localparam int MaxScale = 28;
   localparam int WideW = 256;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_POS = 2'd1;
   localparam logic [1:0] STATUS_NEG = 2'd2;

   typedef struct packed {
      logic        action;
      logic [63:0] a_low;
      logic [31:0] a_high;
      logic [4:0]  a_scale;
      logic        a_negative;
      logic [63:0] b_low;
      logic [31:0] b_high;
      logic [4:0]  b_scale;
      logic        b_negative;
   } req_type;

   typedef struct packed {
      logic [63:0] sum_low;
      logic [31:0] sum_high;
      logic [4:0]  sum_scale;
      logic        sum_negative;
      logic [1:0]  status;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/decimal96_add_subtract_unit.sv
// Decimal add/subtract: 96-bit magnitudes with decimal scales, rounded half to even.
// Alignment multiplies the operand with the smaller scale by ten, once per unit of scale
// difference; each reduction runs the divide by ten, and a rounding carry reduces again.
// A new item is accepted only after the last result; busy stays high through the result cycle.
// Synchronous active-high reset returns the sequencer to idle; no result is pending.
// The receiver cannot stall: rsp_valid is high one cycle per result.
`default_nettype none
`include "decimal96_add_subtract_unit_defines.svh"
module decimal96_add_subtract_unit import das_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_item,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ALIGN = 7'b0000010,
      S_ADD   = 7'b0000100,
      S_CHECK = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_ROUND = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [WideW-1:0] a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [4:0]       cnt_ff, cnt_in, scale_ff, scale_in;
   logic             na_ff, na_in, nb_ff, nb_in, sub_ff, sub_in, neg_ff, neg_in;
   logic [3:0]       digit_ff, digit_in;
   logic             sticky_ff, sticky_in, alb_ff, alb_in;
   logic             div_go, div_done;
   logic [WideW-1:0] div_q;
   logic [3:0]       div_rem;
   logic [WideW-1:0] times10;
   logic             above96, rnd_up;
   rsp_type          rsp_in, rsp_ff;
   logic             valid_ff;

   das_div10 u_div (
      .clock(clock), .reset(reset), .go(div_go), .value(r_ff),
      .done(div_done), .quotient(div_q), .remainder(div_rem)
   );

   // One shared times-ten shifter, applied to the operand with the smaller scale.
   assign times10 = alb_ff ? ((a_ff << 3) + (a_ff << 1)) : ((b_ff << 3) + (b_ff << 1));
   assign above96 = |r_ff[WideW-1:96];
   assign rnd_up = (digit_ff > 4'd5) ||
                   ((digit_ff == 4'd5) && (sticky_ff || r_ff[0]));

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff;
      cnt_in = cnt_ff; scale_in = scale_ff;
      na_in = na_ff; nb_in = nb_ff; sub_in = sub_ff; neg_in = neg_ff;
      digit_in = digit_ff; sticky_in = sticky_ff; alb_in = alb_ff;
      div_go = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               a_in = {160'd0, req_item.a_high, req_item.a_low};
               b_in = {160'd0, req_item.b_high, req_item.b_low};
               sub_in = req_item.action;
               na_in = req_item.a_negative;
               nb_in = req_item.b_negative ^ req_item.action;
               // alb: a's scale is not above b's, so a is the one scaled up.
               alb_in = req_item.a_scale <= req_item.b_scale;
               if (req_item.a_scale <= req_item.b_scale) begin
                  cnt_in = req_item.b_scale - req_item.a_scale;
                  scale_in = req_item.b_scale;
               end else begin
                  cnt_in = req_item.a_scale - req_item.b_scale;
                  scale_in = req_item.a_scale;
               end
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            if (cnt_ff == 5'd0) begin
               state_in = S_ADD;
            end else begin
               if (alb_ff) a_in = times10;
               else b_in = times10;
               cnt_in = cnt_ff - 5'd1;
            end
         end
         S_ADD: begin
            if (na_ff == nb_ff) begin
               r_in = a_ff + b_ff;
               neg_in = na_ff;
            end else if (a_ff < b_ff) begin
               r_in = b_ff - a_ff;
               neg_in = nb_ff;
            end else begin
               r_in = a_ff - b_ff;
               neg_in = na_ff;
            end
            digit_in = 4'd0;
            sticky_in = 1'b0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((above96 || scale_ff > 5'(MaxScale)) && scale_ff != 5'd0) begin
               div_go = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_ROUND;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (digit_ff != 4'd0) sticky_in = 1'b1;
               digit_in = div_rem;
               r_in = div_q;
               scale_in = scale_ff - 5'd1;
               state_in = S_CHECK;
            end
         end
         S_ROUND: begin
            digit_in = 4'd0;
            sticky_in = 1'b0;
            if (rnd_up) begin
               r_in = r_ff + 256'd1;
               // A carry past 96 bits reduces again while the scale is above zero.
               if (|r_in[WideW-1:96] && scale_ff != 5'd0) state_in = S_CHECK;
               else state_in = S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (above96) begin
               rsp_in = '0;
               rsp_in.status = neg_ff ? STATUS_NEG : STATUS_POS;
            end else begin
               rsp_in.sum_low = r_ff[63:0];
               rsp_in.sum_high = r_ff[95:64];
               rsp_in.status = STATUS_OK;
               if (sub_ff && r_ff == '0) begin
                  rsp_in.sum_scale = 5'd0;
                  rsp_in.sum_negative = 1'b0;
               end else begin
                  rsp_in.sum_scale = scale_ff;
                  rsp_in.sum_negative = neg_ff;
               end
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == S_DONE);
      end
      a_ff <= a_in; b_ff <= b_in; r_ff <= r_in;
      cnt_ff <= cnt_in; scale_ff <= scale_in;
      na_ff <= na_in; nb_ff <= nb_in; sub_ff <= sub_in; neg_ff <= neg_in;
      digit_ff <= digit_in; sticky_ff <= sticky_in; alb_ff <= alb_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_item = rsp_ff;

   `DAS_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy,
      "busy did not rise after an accepted item")
   `DAS_ASSERT_NXT(a_one_result, clock, reset, rsp_valid, !rsp_valid,
      "result strobe lasted more than one cycle")
   `DAS_ASSERT_IMP(a_status_code, clock, reset, rsp_valid,
      rsp_item.status == STATUS_OK || rsp_item.status == STATUS_POS ||
      rsp_item.status == STATUS_NEG, "illegal status code")
   `DAS_ASSERT_IMP(a_error_zero, clock, reset, rsp_valid && rsp_item.status != STATUS_OK,
      rsp_item.sum_low == 64'd0 && rsp_item.sum_high == 32'd0,
      "overflow result carries a nonzero magnitude")
endmodule
`default_nettype wire

>>> rtl/das_div10.sv
// Divides a 256-bit value by ten, one 32-bit limb per cycle, top limb first.
// Depends on das_pkg.
`default_nettype none
module das_div10 import das_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic [WideW-1:0]   value,
   output logic                    done,
   output logic [WideW-1:0]        quotient,
   output logic [3:0]              remainder
);
   logic [2:0]        limb_ff, limb_in;
   logic              run_ff, run_in;
   logic [3:0]        rem_ff, rem_in;
   logic [WideW-1:0]  q_ff, q_in;
   logic [35:0]       part;
   logic [31:0]       qlimb;
   logic [35:0]       prod;

   // Partial dividend is below 10 * 2^32, so the reciprocal quotient needs one fix-up.
   // The reciprocal is truncated, so the estimate is never above the true quotient.
   assign part  = {rem_ff, value[limb_ff*32 +: 32]};
   assign qlimb = 32'((69'(part) * 69'h1_9999_9999) >> 36);
   assign prod  = 36'(qlimb) * 36'd10;
   always_comb begin
      rem_in = rem_ff;
      q_in = q_ff;
      limb_in = limb_ff;
      run_in = run_ff;
      if (go) begin
         run_in = 1'b1;
         limb_in = 3'd7;
         rem_in = 4'd0;
      end else if (run_ff) begin
         if (part - prod >= 36'd10) begin
            q_in[limb_ff*32 +: 32] = qlimb + 32'd1;
            rem_in = 4'(part - prod - 36'd10);
         end else begin
            q_in[limb_ff*32 +: 32] = qlimb;
            rem_in = 4'(part - prod);
         end
         limb_in = limb_ff - 3'd1;
         if (limb_ff == 3'd0) run_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         limb_ff <= 3'd0;
      end else begin
         run_ff <= run_in;
         limb_ff <= limb_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
   end
   assign done = run_ff && (limb_ff == 3'd0);
   assign quotient = q_in;
   assign remainder = rem_in;
endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the 96-bit scaled decimal add/subtract unit.
// Depends on das_pkg and decimal96_add_subtract_unit; an internal predictor checks each sum.
`timescale 1ns / 1ps
module tb;
   import das_pkg::*;

   class sum_scoreboard;
      rsp_type pending_sums[$];
      int mismatch_count;
      int checked_count;

      // Exact sum of two scaled decimals, reduced and rounded half to even.
      function automatic rsp_type predict_sum(req_type item);
         logic [255:0] mag_a, mag_b, exact;
         int scale, digit;
         bit neg_a, neg_b, neg, sticky, rounded_up;
         rsp_type sum;
         mag_a = {160'd0, item.a_high, item.a_low};
         mag_b = {160'd0, item.b_high, item.b_low};
         neg_a = item.a_negative;
         neg_b = item.b_negative ^ item.action;
         if (item.a_scale <= item.b_scale) begin
            for (int i = item.a_scale; i < item.b_scale; i++) mag_a = mag_a * 10;
            scale = item.b_scale;
         end else begin
            for (int i = item.b_scale; i < item.a_scale; i++) mag_b = mag_b * 10;
            scale = item.a_scale;
         end
         if (neg_a == neg_b) begin
            exact = mag_a + mag_b;
            neg = neg_a;
         end else if (mag_a < mag_b) begin
            exact = mag_b - mag_a;
            neg = neg_b;
         end else begin
            exact = mag_a - mag_b;
            neg = neg_a;
         end
         forever begin
            digit = 0;
            sticky = 0;
            rounded_up = 0;
            while ((exact[255:96] != 0 || scale > MaxScale) && scale > 0) begin
               if (digit != 0) sticky = 1;
               digit = int'(exact % 10);
               exact = exact / 10;
               scale--;
            end
            if (digit > 5 || (digit == 5 && (sticky || exact[0]))) begin
               exact = exact + 1;
               rounded_up = 1;
            end
            if (!(rounded_up && exact[255:96] != 0 && scale > 0)) break;
         end
         sum = '0;
         if (exact[255:96] != 0) begin
            sum.status = neg ? STATUS_NEG : STATUS_POS;
            return sum;
         end
         if (item.action && exact == 0) begin
            scale = 0;
            neg = 0;
         end
         sum.sum_low = exact[63:0];
         sum.sum_high = exact[95:64];
         sum.sum_scale = scale[4:0];
         sum.sum_negative = neg;
         sum.status = STATUS_OK;
         return sum;
      endfunction

      function void note_item(req_type item);
         pending_sums.push_back(predict_sum(item));
      endfunction

      function void check_sum(rsp_type got);
         rsp_type want;
         if (pending_sums.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected sum %h", got);
            return;
         end
         want = pending_sums.pop_front();
         checked_count++;
         if (got.sum_low !== want.sum_low || got.sum_high !== want.sum_high ||
             got.sum_scale !== want.sum_scale || got.sum_negative !== want.sum_negative ||
             got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Sum mismatch: expected %h_%h s%0d n%0d st%0d, got %h_%h s%0d n%0d st%0d",
                  want.sum_high, want.sum_low, want.sum_scale, want.sum_negative, want.status,
                  got.sum_high, got.sum_low, got.sum_scale, got.sum_negative, got.status);
         end
      endfunction
   endclass

   localparam int WatchdogLimit = 20000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   req_type req_item = '0;
   logic busy, rsp_valid;
   rsp_type rsp_item;
   sum_scoreboard sums = new();
   int idle_cycles = 0;
   int stimulus_done = 0;

   decimal96_add_subtract_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sums.check_sum(rsp_item);
      if (!reset && (rsp_valid || (start && !busy))) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Watchdog expired");
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [95:0] random_magnitude();
      case ($urandom_range(0, 5))
         0: return {$urandom(), $urandom(), $urandom()};
         1: return '1 - $urandom_range(0, 20);
         2: return 96'($urandom_range(0, 1000));
         3: return {32'd0, $urandom(), $urandom()};
         4: return 96'd1 << $urandom_range(0, 95);
         default: return {$urandom(), $urandom(), $urandom()} >> $urandom_range(0, 95);
      endcase
   endfunction

   function automatic req_type make_item(bit action, logic [95:0] a, int a_scale, bit a_neg,
                                         logic [95:0] b, int b_scale, bit b_neg);
      req_type item;
      item.action = action;
      {item.a_high, item.a_low} = a;
      item.a_scale = a_scale[4:0];
      item.a_negative = a_neg;
      {item.b_high, item.b_low} = b;
      item.b_scale = b_scale[4:0];
      item.b_negative = b_neg;
      return item;
   endfunction

   // Hands one item to the block and records its expected sum once accepted.
   // Start stays high afterwards; busy holds the block off until the next item is driven.
   task automatic send_item(req_type item);
      start <= 1;
      req_item <= item;
      do @(posedge clock); while (busy);
      sums.note_item(item);
   endtask

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [95:0] max_mag;
      int burst;
      max_mag = '1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Extremes, overflow in both signs, exact zeros, rounding ties and scales above 28.
      send_item(make_item(0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(1, 5, 3, 0, 5, 3, 0));
      send_item(make_item(1, 5, 3, 1, 5, 3, 1));
      send_item(make_item(0, 5, 3, 1, 5, 3, 0));
      send_item(make_item(0, max_mag, 0, 0, 1, 0, 0));
      send_item(make_item(0, max_mag, 0, 1, 1, 0, 1));
      send_item(make_item(1, max_mag, 0, 1, 1, 0, 0));
      send_item(make_item(0, max_mag, 28, 0, max_mag, 28, 0));
      send_item(make_item(0, max_mag, 0, 0, 1, 28, 0));
      send_item(make_item(0, max_mag, 0, 0, 5, 1, 0));
      send_item(make_item(0, max_mag - 1, 0, 0, 5, 1, 0));
      send_item(make_item(0, max_mag, 1, 0, max_mag, 1, 0));
      send_item(make_item(1, 7, 31, 0, 3, 29, 1));
      send_item(make_item(0, 15, 29, 0, 0, 0, 0));
      send_item(make_item(0, 25, 30, 1, 0, 31, 0));
      send_item(make_item(1, max_mag, 28, 0, 1, 0, 0));
      send_item(make_item(1, 1, 0, 0, max_mag, 28, 0));
      send_item(make_item(0, max_mag, 5, 1, max_mag, 0, 1));
      send_item(make_item(1, 12345, 2, 0, 12345, 7, 0));
      start <= 0;
      // Hold off until every directed sum has come back.
      while (sums.pending_sums.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      for (int n = 0; n < 600; ) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && n < 600; k++, n++) begin
            int sa, sb;
            sa = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 28);
            sb = ($urandom_range(0, 3) == 0) ? sa : $urandom_range(0, 28);
            send_item(make_item($urandom_range(0, 1), random_magnitude(), sa,
                                $urandom_range(0, 1), random_magnitude(), sb,
                                $urandom_range(0, 1)));
         end
         idle_gap();
      end
      start <= 0;
      while (sums.pending_sums.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Checked %0d sums over aligned, mixed-sign, overflow and rounding cases.",
               sums.checked_count);
      if (sums.mismatch_count == 0 && sums.pending_sums.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl
rtl/das_pkg.sv
rtl/das_div10.sv
rtl/decimal96_add_subtract_unit.sv
bench/tb.sv
